@@ rtl/npc_pkg.sv @@
// Package for the nearest palette color search.
// Holds sizes, command codes, the controller state type and the scan control structs.
// No dependencies.
package npc_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W = $clog2(PALETTE_ENTRIES);
  localparam int COLOR_W = 24;
  localparam int SQ_W = 16;
  localparam int DIST_W = SQ_W + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MAP  = 1'b1
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } scan_ctrl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [IDX_W-1:0] index;
  } scan_status_t;

endpackage

@@ rtl/npc_req_if.sv @@
// Request channel of the nearest palette color search.
// Carries a load or map request with valid and ready; no dependencies.
interface npc_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, cmd, entry_index, red, green, blue, input ready);
  modport sink (input valid, cmd, entry_index, red, green, blue, output ready);
endinterface

@@ rtl/npc_rsp_if.sv @@
// Result channel of the nearest palette color search.
// Carries the palette index with valid and ready; no dependencies.
interface npc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;

  modport source (output valid, color_index, input ready);
  modport sink (input valid, color_index, output ready);
endinterface

@@ rtl/npc_palette_mem.sv @@
// Palette memory: one write port and one registered read port.
// Per-entry valid bits make entries that were never written read as black.
// Depends on npc_pkg.
module npc_palette_mem
  import npc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   waddr,
  input  logic [COLOR_W-1:0] wdata,
  input  logic [IDX_W-1:0]   raddr,
  output logic [COLOR_W-1:0] rdata
);

  logic [COLOR_W-1:0]         mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] vld;
  logic [COLOR_W-1:0]         rdata_q;
  logic                       rvld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[waddr] <= 1'b1;
      end
      rvld_q <= vld[raddr];
    end
  end

  assign rdata = rvld_q ? rdata_q : '0;

endmodule

@@ rtl/npc_search.sv @@
// Scan engine: walks the palette memory one entry per cycle, computes the squared
// RGB distance in two stages and keeps the nearest index. Depends on npc_pkg.
module npc_search
  import npc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  scan_ctrl_t         ctrl,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  output logic [IDX_W-1:0]   raddr,
  input  logic [COLOR_W-1:0] rdata,
  output scan_status_t       status
);

  function automatic logic [SQ_W-1:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d * d);
  endfunction

  logic [7:0]        pix_r;
  logic [7:0]        pix_g;
  logic [7:0]        pix_b;
  logic              issuing;
  logic [IDX_W-1:0]  cnt;
  logic              s1_vld;
  logic              s1_last;
  logic [IDX_W-1:0]  s1_idx;
  logic              s2_vld;
  logic              s2_last;
  logic [IDX_W-1:0]  s2_idx;
  logic [SQ_W-1:0]   sq_r;
  logic [SQ_W-1:0]   sq_g;
  logic [SQ_W-1:0]   sq_b;
  logic [DIST_W-1:0] cur_dist;
  logic [DIST_W-1:0] best_dist;
  logic [IDX_W-1:0]  best_idx;
  logic              done;
  logic              better;

  assign raddr    = cnt;
  assign cur_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  assign better   = (s2_idx == '0) || (cur_dist < best_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      cnt     <= '0;
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (ctrl.start) begin
        issuing <= 1'b1;
        cnt     <= '0;
      end else if (issuing) begin
        if (cnt == LAST_IDX) begin
          issuing <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
      s1_vld <= issuing;
      s2_vld <= s1_vld;
      if (ctrl.start || ctrl.ack) begin
        done <= 1'b0;
      end else if (s2_vld && s2_last) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      pix_r <= red;
      pix_g <= green;
      pix_b <= blue;
    end
    s1_idx  <= cnt;
    s1_last <= (cnt == LAST_IDX);
    s2_idx  <= s1_idx;
    s2_last <= s1_last;
    sq_r    <= sq_diff(pix_r, rdata[23:16]);
    sq_g    <= sq_diff(pix_g, rdata[15:8]);
    sq_b    <= sq_diff(pix_b, rdata[7:0]);
    if (s2_vld && better) begin
      best_dist <= cur_dist;
      best_idx  <= s2_idx;
    end
  end

  assign status.busy  = issuing || s1_vld || s2_vld;
  assign status.done  = done;
  assign status.index = best_idx;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> !status.busy)
    else $error("scan restarted while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    !(status.done && status.busy))
    else $error("scan done while still busy");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (s2_vld && s2_last && !ctrl.ack) |=> status.done)
    else $error("last entry did not finish the scan");

endmodule

@@ rtl/nearest_palette_color.sv @@
// Nearest palette color search, top level. A load request writes one palette entry
// and gives no result; a load to an index at or beyond PALETTE_ENTRIES is dropped.
// A map request reads the palette memory one entry per cycle through its single
// read port; the result passes the memory read register, the squared distance
// registers and the best-index register before it is registered at the output.
// A new request is taken in the next cycle, even while the result still waits on
// the response channel. Ties return the lowest index. Reset marks every entry as
// black at once, with no clearing pass. Depends on npc_pkg, npc_req_if, npc_rsp_if,
// npc_palette_mem and npc_search.
module nearest_palette_color
  import npc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  npc_req_if.sink  req,
  npc_rsp_if.source rsp
);

  state_t             state;
  state_t             state_next;
  scan_ctrl_t         ctrl;
  scan_status_t       status;
  logic               accept;
  logic               wr_en;
  logic               load_out;
  logic [IDX_W-1:0]   raddr;
  logic [COLOR_W-1:0] rdata;
  logic               out_valid;
  logic [7:0]         out_idx;

  assign accept = req.valid && req.ready;
  assign wr_en  = accept && (req.cmd == CMD_LOAD)
                  && ({1'b0, req.entry_index} < 9'(PALETTE_ENTRIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    ctrl       = '0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid && (req.cmd == CMD_MAP)) begin
          ctrl.start = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.done && (!out_valid || rsp.ready)) begin
          ctrl.ack   = 1'b1;
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_idx <= 8'(status.index);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.color_index = out_idx;

  npc_palette_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .wr_en (wr_en),
    .waddr (IDX_W'(req.entry_index)),
    .wdata ({req.red, req.green, req.blue}),
    .raddr (raddr),
    .rdata (rdata)
  );

  npc_search u_search (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .red    (req.red),
    .green  (req.green),
    .blue   (req.blue),
    .raddr  (raddr),
    .rdata  (rdata),
    .status (status)
  );

  a_map_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.cmd == CMD_MAP)) |=> (state == ST_SCAN) && status.busy)
    else $error("map request did not start a scan");

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for nearest_palette_color: palette loads and pixel maps,
// with results checked against directed answers or a local search over a shadow copy of the palette.
// Depends on npc_pkg, npc_req_if, npc_rsp_if and the nearest_palette_color RTL.
module testbench
  import npc_pkg::*;
;

  localparam int RANDOM_ITEMS = 700;
  localparam int QUIET_ITEMS = 100;
  localparam int SETTLE_CYCLES = PALETTE_ENTRIES + 16;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         has_answer;
    logic [7:0] answer;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 21;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_MAP,  8'd0,   8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
    '{CMD_MAP,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
    '{CMD_LOAD, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
    '{CMD_MAP,  8'd0,   8'd255, 8'd255, 8'd255, 1'b1, 8'd255},
    '{CMD_MAP,  8'd255, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
    '{CMD_LOAD, 8'd0,   8'd255, 8'd0,   8'd0,   1'b0, 8'd0},
    '{CMD_MAP,  8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd1},
    '{CMD_MAP,  8'd0,   8'd255, 8'd0,   8'd0,   1'b1, 8'd0},
    '{CMD_LOAD, 8'd128, 8'd0,   8'd255, 8'd0,   1'b0, 8'd0},
    '{CMD_LOAD, 8'd200, 8'd0,   8'd255, 8'd0,   1'b0, 8'd0},
    '{CMD_MAP,  8'd0,   8'd0,   8'd255, 8'd0,   1'b1, 8'd128},
    '{CMD_LOAD, 8'd7,   8'd0,   8'd0,   8'd255, 1'b0, 8'd0},
    '{CMD_MAP,  8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 8'd7},
    '{CMD_LOAD, 8'd10,  8'd100, 8'd100, 8'd100, 1'b0, 8'd0},
    '{CMD_LOAD, 8'd11,  8'd102, 8'd100, 8'd100, 1'b0, 8'd0},
    '{CMD_MAP,  8'd0,   8'd101, 8'd100, 8'd100, 1'b0, 8'd0},
    '{CMD_LOAD, 8'd170, 8'd170, 8'd85,  8'd170, 1'b0, 8'd0},
    '{CMD_LOAD, 8'd85,  8'd85,  8'd170, 8'd85,  1'b0, 8'd0},
    '{CMD_MAP,  8'd0,   8'd170, 8'd85,  8'd170, 1'b0, 8'd0},
    '{CMD_MAP,  8'd0,   8'd128, 8'd127, 8'd128, 1'b0, 8'd0},
    '{CMD_MAP,  8'd0,   8'd254, 8'd254, 8'd254, 1'b1, 8'd255}
  };

  logic clk;
  logic rst;

  npc_req_if req ();
  npc_rsp_if rsp ();

  nearest_palette_color i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic [COLOR_W-1:0] palette_shadow [PALETTE_ENTRIES] = '{default: '0};
  logic [7:0]         pending_index_q [$];

  bit quiet_phase = 1'b0;
  int load_count = 0;
  int map_count = 0;
  int result_count = 0;
  int error_count = 0;
  int stalled_cycles = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [SQ_W-1:0] square_gap(logic [7:0] a, logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic logic [7:0] nearest_entry(logic [7:0] r, logic [7:0] g,
                                               logic [7:0] b);
    logic [7:0]        best;
    logic [DIST_W-1:0] best_dist;
    logic [DIST_W-1:0] cur_dist;
    best = '0;
    best_dist = '1;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      cur_dist = square_gap(r, palette_shadow[i][23:16])
               + square_gap(g, palette_shadow[i][15:8])
               + square_gap(b, palette_shadow[i][7:0]);
      if (i == 0 || cur_dist < best_dist) begin
        best = 8'(i);
        best_dist = cur_dist;
      end
    end
    return best;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_request(input cmd_t c, input logic [7:0] idx, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b,
                              input bit has_answer, input logic [7:0] answer);
    logic [7:0] predicted;
    req.valid <= 1'b1;
    req.cmd <= c;
    req.entry_index <= idx;
    req.red <= r;
    req.green <= g;
    req.blue <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (c == CMD_LOAD) begin
      if (int'(idx) < PALETTE_ENTRIES) palette_shadow[idx] = {r, g, b};
      load_count++;
    end else begin
      predicted = nearest_entry(r, g, b);
      pending_index_q.push_back(has_answer ? answer : predicted);
      map_count++;
    end
  endtask

  task automatic hold_off(input int cycles);
    req.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    int                 sel;
    logic [COLOR_W-1:0] color;
    rst = 1'b1;
    req.valid = 1'b0;
    req.cmd = CMD_LOAD;
    req.entry_index = '0;
    req.red = '0;
    req.green = '0;
    req.blue = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      send_request(directed_rows[k].cmd, directed_rows[k].entry_index, directed_rows[k].red,
                   directed_rows[k].green, directed_rows[k].blue,
                   directed_rows[k].has_answer, directed_rows[k].answer);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_index_q.size() != 0) @(posedge clk);
      end
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_phase = 1'b1;
      if (!quiet_phase && $urandom_range(0, 4) == 0) hold_off($urandom_range(1, 16));
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        // Copies of existing colors create ties that only the lowest index may win.
        if (sel < 8) color = palette_shadow[$urandom_range(0, PALETTE_ENTRIES - 1)];
        else if (sel < 14) color = {8'($urandom_range(0, 1) * 255),
                                    8'($urandom_range(0, 1) * 255),
                                    8'($urandom_range(0, 1) * 255)};
        else color = 24'($urandom);
        send_request(CMD_LOAD, 8'($urandom_range(0, 255)), color[23:16], color[15:8],
                     color[7:0], 1'b0, 8'd0);
      end else begin
        if (sel < 55) color = palette_shadow[$urandom_range(0, PALETTE_ENTRIES - 1)];
        else if (sel < 65) color = palette_shadow[$urandom_range(0, PALETTE_ENTRIES - 1)]
                                   ^ 24'($urandom_range(1, 7));
        else if (sel < 72) color = {8'($urandom_range(0, 1) * 255),
                                    8'($urandom_range(0, 1) * 255),
                                    8'($urandom_range(0, 1) * 255)};
        else color = 24'($urandom);
        send_request(CMD_MAP, 8'($urandom_range(0, 255)), color[23:16], color[15:8],
                     color[7:0], 1'b0, 8'd0);
      end
    end

    req.valid <= 1'b0;
    while (pending_index_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_index_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_index_q.size()));

    $display("Ran %0d palette loads and %0d pixel maps; %0d results checked, %0d errors.",
             load_count, map_count, result_count, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    rsp.ready = 1'b0;
    forever begin
      if (!quiet_phase && $urandom_range(0, 2) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_index_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, color_index %0d", rsp.color_index));
      end else begin
        if (rsp.color_index !== pending_index_q[0])
          report_mismatch($sformatf("color_index %0d, expected %0d",
                                    rsp.color_index, pending_index_q[0]));
        void'(pending_index_q.pop_front());
        result_count++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

endmodule

@@ files.f @@
rtl/npc_pkg.sv
rtl/npc_req_if.sv
rtl/npc_rsp_if.sv
rtl/npc_palette_mem.sv
rtl/npc_search.sv
rtl/nearest_palette_color.sv
bench/testbench.sv
